// ----- rtl/core/balloc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy allocator package
// Port widths, result codes, default sizes and the top-order helper.
// ----------------------------------------------------------------------------
package balloc_pkg;

  localparam int DEF_NUM_UNITS  = 1024;
  localparam int DEF_UNIT_BYTES = 16;

  localparam int SIZE_W    = 15;
  localparam int OFS_W     = 14;
  localparam int OUT_ORD_W = 4;
  localparam int STATUS_W  = 2;

  localparam logic REQ_ALLOC = 1'b0;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  // Largest k with 2^k not above n.
  function automatic int top_order(input int n);
    int k;
    k = 0;
    for (int i = 1; i < 32; i++) begin
      if ((longint'(1) << i) <= longint'(n)) begin
        k = i;
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/buddy_allocator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy allocator core
// Keeps one entry (order and used bit) per unit in a synchronous memory and
// serves allocate and free requests by read, modify and write-back sequences.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-------------------------------
//   request  | in        | in_valid_i/in_ready_o  | req_type, request_size,
//            |           |                        | block_offset
//   response | out       | out_valid_o/out_ready_i| status, result_offset,
//            |           |                        | result_order
//
// One request is in work at a time; a request beat is taken only in the idle
// state. An allocate visits table entries, the scan being repeated for each
// larger order tried, then splits the block down, marks it and loads the
// response; a size above the pool goes straight to the response. A free
// checks the offset, reads the block entry and examines one buddy per merge,
// at most the top order of them; a rejected free goes straight to the response.
// After reset a clearing pass writes all NUM_UNITS entries, one per cycle,
// before the first request is taken. A stalled response beat is held in the
// output register while the next request is already taken and worked on.
// ----------------------------------------------------------------------------
module buddy_allocator_core
  import balloc_pkg::*;
#(
  parameter int NUM_UNITS  = DEF_NUM_UNITS,
  parameter int UNIT_BYTES = DEF_UNIT_BYTES
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  input  wire logic [SIZE_W-1:0]    request_size_i,
  input  wire logic [OFS_W-1:0]     block_offset_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic [OFS_W-1:0]          result_offset_o,
  output logic [OUT_ORD_W-1:0]      result_order_o
);

  localparam int MAXO    = top_order(NUM_UNITS);
  localparam int AW      = $clog2(NUM_UNITS);
  localparam int CNT_W   = AW + 1;
  localparam int ORD_W   = $clog2(MAXO + 1);
  localparam int ENT_W   = ORD_W + 1;
  localparam int UB_W    = $clog2(UNIT_BYTES + 1);
  localparam int PW      = (AW + UB_W > OFS_W) ? AW + UB_W : OFS_W;
  localparam int RECIP_S = OFS_W + $clog2(UNIT_BYTES);
  localparam longint RECIP_M = ((longint'(1) << RECIP_S) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int RP_W    = 2 * OFS_W + 2;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_SPLIT  = 10'b0000001000,
    S_MARK   = 10'b0000010000,
    S_FCHK   = 10'b0000100000,
    S_FUSED  = 10'b0001000000,
    S_FMERGE = 10'b0010000000,
    S_RESP   = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [ORD_W-1:0]      o_q, o_d;
  logic [ORD_W-1:0]      d_q, d_d;
  logic [OFS_W-1:0]      q_q, q_d;
  logic [OFS_W-1:0]      ofs_q, ofs_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic [AW-1:0]         res_idx_q, res_idx_d;
  logic [ORD_W-1:0]      res_ord_q, res_ord_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [OFS_W-1:0]      offset_q, offset_d;
  logic [OUT_ORD_W-1:0]  order_q, order_d;

  logic [ENT_W-1:0]      mem [NUM_UNITS];
  logic [ENT_W-1:0]      mem_rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ENT_W-1:0]      mem_wdata;

  logic [ORD_W-1:0]      size_ord;
  logic                  size_fits;
  logic [RP_W-1:0]       recip_prod;
  logic [OFS_W-1:0]      recip_q;
  logic [31:0]           chk_prod;
  logic [PW-1:0]         res_prod;
  logic [ORD_W-1:0]      e_ord;
  logic                  e_used;
  logic [ORD_W-1:0]      step_o;
  logic [CNT_W-1:0]      next_idx;
  logic [CNT_W-1:0]      split_up;
  logic [AW-1:0]         aidx;
  logic [AW-1:0]         merge_low;
  logic [ORD_W-1:0]      o_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    size_ord  = '0;
    size_fits = 1'b0;
    for (int k = MAXO; k >= 0; k--) begin
      if (32'(request_size_i) <= (32'(UNIT_BYTES) << k)) begin
        size_ord  = ORD_W'(k);
        size_fits = 1'b1;
      end
    end
  end

  assign recip_prod = RP_W'(block_offset_i) * RP_W'(RECIP_M);
  assign recip_q    = OFS_W'(recip_prod >> RECIP_S);
  assign chk_prod   = 32'(q_q) * 32'(UNIT_BYTES);
  assign res_prod   = PW'(res_idx_q) * PW'(UNIT_BYTES);

  assign e_ord     = mem_rdata_q[ORD_W-1:0];
  assign e_used    = mem_rdata_q[ORD_W];
  assign step_o    = (e_ord > o_q) ? e_ord : o_q;
  assign next_idx  = idx_q + (CNT_W'(1) << step_o);
  assign split_up  = idx_q + (CNT_W'(1) << (o_q - ORD_W'(1)));
  assign aidx      = idx_q[AW-1:0];
  assign merge_low = aidx & ~(AW'(1) << o_q);
  assign o_inc     = o_q + ORD_W'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    o_d         = o_q;
    d_d         = d_q;
    q_d         = q_q;
    ofs_d       = ofs_q;
    res_st_d    = res_st_q;
    res_idx_d   = res_idx_q;
    res_ord_d   = res_ord_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    offset_d    = offset_q;
    order_d     = order_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) ? {1'b0, ORD_W'(MAXO)} : '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NUM_UNITS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_ALLOC) begin
            if (size_fits) begin
              d_d       = size_ord;
              o_d       = size_ord;
              idx_d     = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = S_SCAN;
            end else begin
              res_st_d  = ST_NOMEM;
              res_idx_d = '0;
              res_ord_d = '0;
              state_d   = S_RESP;
            end
          end else begin
            q_d     = recip_q;
            ofs_d   = block_offset_i;
            state_d = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (e_ord == o_q && !e_used) begin
          state_d = (o_q == d_q) ? S_MARK : S_SPLIT;
        end else if (next_idx < CNT_W'(NUM_UNITS)) begin
          idx_d     = next_idx;
          mem_re    = 1'b1;
          mem_raddr = next_idx[AW-1:0];
        end else if (o_q == ORD_W'(MAXO)) begin
          res_st_d  = ST_NOMEM;
          res_idx_d = '0;
          res_ord_d = '0;
          state_d   = S_RESP;
        end else begin
          o_d       = o_inc;
          idx_d     = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
      end
      S_SPLIT: begin
        if (split_up < CNT_W'(NUM_UNITS)) begin
          mem_we    = 1'b1;
          mem_waddr = split_up[AW-1:0];
          mem_wdata = {1'b0, o_q - ORD_W'(1)};
        end
        o_d = o_q - ORD_W'(1);
        if (o_q - ORD_W'(1) == d_q) begin
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = aidx;
        mem_wdata = {1'b1, d_q};
        res_st_d  = ST_OK;
        res_idx_d = aidx;
        res_ord_d = d_q;
        state_d   = S_RESP;
      end
      S_FCHK: begin
        if (chk_prod != 32'(ofs_q) || 32'(q_q) >= (32'd1 << MAXO)) begin
          res_st_d  = ST_BADFREE;
          res_idx_d = '0;
          res_ord_d = '0;
          state_d   = S_RESP;
        end else begin
          idx_d     = CNT_W'(q_q);
          mem_re    = 1'b1;
          mem_raddr = AW'(q_q);
          state_d   = S_FUSED;
        end
      end
      S_FUSED: begin
        if (!e_used) begin
          res_st_d  = ST_BADFREE;
          res_idx_d = '0;
          res_ord_d = '0;
          state_d   = S_RESP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = aidx;
          mem_wdata = {1'b0, e_ord};
          o_d       = e_ord;
          if (e_ord >= ORD_W'(MAXO)) begin
            res_st_d  = ST_OK;
            res_idx_d = aidx;
            res_ord_d = e_ord;
            state_d   = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = aidx ^ (AW'(1) << e_ord);
            state_d   = S_FMERGE;
          end
        end
      end
      S_FMERGE: begin
        if (!e_used && e_ord == o_q) begin
          mem_we    = 1'b1;
          mem_waddr = merge_low;
          mem_wdata = {1'b0, o_inc};
          idx_d     = CNT_W'(merge_low);
          o_d       = o_inc;
          if (o_inc == ORD_W'(MAXO)) begin
            res_st_d  = ST_OK;
            res_idx_d = merge_low;
            res_ord_d = o_inc;
            state_d   = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = merge_low ^ (AW'(1) << o_inc);
          end
        end else begin
          res_st_d  = ST_OK;
          res_idx_d = aidx;
          res_ord_d = o_q;
          state_d   = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_st_q;
          offset_d    = OFS_W'(res_prod);
          order_d     = OUT_ORD_W'(res_ord_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    o_q       <= o_d;
    d_q       <= d_d;
    q_q       <= q_d;
    ofs_q     <= ofs_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    res_ord_q <= res_ord_d;
    status_q  <= status_d;
    offset_q  <= offset_d;
    order_q   <= order_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_offset_o = offset_q;
  assign result_order_o  = order_q;

endmodule
`default_nettype wire

// ----- tb/sv/buddy_allocator_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy allocator core testbench
// Drives allocate and free request beats through the valid/ready request
// channel and checks every response beat against a behavioural model of the
// unit table kept in step per taken request beat, or a directed row's fixed
// response. A short directed table runs first, then three random phases with
// differing idle patterns on each side, including a long response hold-off.
// ----------------------------------------------------------------------------
module buddy_allocator_core_tb;
  import balloc_pkg::*;

  localparam int NUM_U       = DEF_NUM_UNITS;
  localparam int UNIT_B      = DEF_UNIT_BYTES;
  localparam int MAX_ORD     = top_order(DEF_NUM_UNITS);
  localparam logic REQ_FREE  = 1'b1;
  localparam int PHASE_ITEMS = 567;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 60000;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIRECTED  = 20;

  typedef struct packed {
    logic [STATUS_W-1:0]  st;
    logic [OFS_W-1:0]     ofs;
    logic [OUT_ORD_W-1:0] ord;
  } alloc_resp_t;

  typedef struct packed {
    logic              rq;
    logic [SIZE_W-1:0] size;
    logic [OFS_W-1:0]  ofs;
    logic              fixed;
    alloc_resp_t       resp;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 req_type_i;
  logic [SIZE_W-1:0]    request_size_i;
  logic [OFS_W-1:0]     block_offset_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATUS_W-1:0]  status_o;
  logic [OFS_W-1:0]     result_offset_o;
  logic [OUT_ORD_W-1:0] result_order_o;

  bit [OUT_ORD_W-1:0] unit_ord [NUM_U];
  bit                 unit_used [NUM_U];
  int                 live_ofs [$];
  alloc_resp_t        resp_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fill_target   = 8;
  int hold_reqs     = 0;
  int bad_beats     = 0;
  int quiet_cycles  = 0;

  always #10 clk_i = ~clk_i;

  buddy_allocator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .request_size_i  (request_size_i),
    .block_offset_i  (block_offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_offset_o (result_offset_o),
    .result_order_o  (result_order_o)
  );

  function automatic void pool_reset();
    for (int i = 0; i < NUM_U; i++) begin
      unit_ord[i]  = '0;
      unit_used[i] = 1'b0;
    end
    unit_ord[0] = OUT_ORD_W'(MAX_ORD);
    live_ofs.delete();
  endfunction

  function automatic int pool_scan(input int d);
    int idx;
    int o;
    idx = 0;
    while (idx < NUM_U) begin
      o = unit_ord[idx];
      if (o == d && !unit_used[idx]) begin
        return idx;
      end
      idx += 1 << ((o > d) ? o : d);
    end
    return -1;
  endfunction

  function automatic alloc_resp_t pool_apply(input logic rq, input logic [SIZE_W-1:0] sz,
                                             input logic [OFS_W-1:0] ofs);
    alloc_resp_t r;
    int want;
    int o;
    int hit;
    int b;
    int up;
    int idx;
    int cur;
    int bud;
    r = '0;
    if (rq == REQ_ALLOC) begin
      want = 0;
      while (want <= MAX_ORD && (UNIT_B << want) < int'(sz)) want++;
      if (want > MAX_ORD) begin
        r.st = ST_NOMEM;
        return r;
      end
      hit = -1;
      for (o = want; o <= MAX_ORD; o++) begin
        hit = pool_scan(o);
        if (hit >= 0) break;
      end
      if (hit < 0) begin
        r.st = ST_NOMEM;
        return r;
      end
      b = hit;
      while (o > want) begin
        up = b + (1 << (o - 1));
        unit_ord[b] = OUT_ORD_W'(o - 1);
        if (up < NUM_U) begin
          unit_ord[up]  = OUT_ORD_W'(o - 1);
          unit_used[up] = 1'b0;
        end
        o--;
      end
      unit_used[b] = 1'b1;
      r.st  = ST_OK;
      r.ofs = OFS_W'(b * UNIT_B);
      r.ord = OUT_ORD_W'(want);
    end else begin
      if (int'(ofs) % UNIT_B != 0) begin
        r.st = ST_BADFREE;
        return r;
      end
      idx = int'(ofs) / UNIT_B;
      if (idx >= (1 << MAX_ORD) || idx >= NUM_U || !unit_used[idx]) begin
        r.st = ST_BADFREE;
        return r;
      end
      unit_used[idx] = 1'b0;
      while (unit_ord[idx] < MAX_ORD) begin
        cur = unit_ord[idx];
        bud = idx ^ (1 << cur);
        if (bud >= NUM_U || unit_used[bud] || unit_ord[bud] != cur) break;
        if (bud < idx) idx = bud;
        unit_ord[idx] = OUT_ORD_W'(cur + 1);
      end
      r.st  = ST_OK;
      r.ofs = OFS_W'(idx * UNIT_B);
      r.ord = unit_ord[idx];
    end
    return r;
  endfunction

  task automatic issue_request(input logic rq, input logic [SIZE_W-1:0] sz,
                               input logic [OFS_W-1:0] ofs, input logic fixed,
                               input alloc_resp_t fixed_resp);
    alloc_resp_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rq;
    request_size_i <= sz;
    block_offset_i <= ofs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = pool_apply(rq, sz, ofs);
    resp_q.push_back(fixed ? fixed_resp : r);
    if (r.st == ST_OK) begin
      if (rq == REQ_ALLOC) begin
        live_ofs.push_back(int'(r.ofs));
      end else begin
        for (int k = 0; k < live_ofs.size(); k++) begin
          if (live_ofs[k] == int'(ofs)) begin
            live_ofs.delete(k);
            break;
          end
        end
      end
    end
  endtask

  task automatic draw_request(output logic rq, output logic [SIZE_W-1:0] sz,
                              output logic [OFS_W-1:0] ofs);
    int roll;
    int ord;
    int pick;
    rq   = REQ_ALLOC;
    sz   = SIZE_W'($urandom_range(0, NUM_U * UNIT_B));
    ofs  = OFS_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          rq  = REQ_FREE;
          ofs = OFS_W'($urandom_range(0, NUM_U - 1) * UNIT_B + $urandom_range(1, UNIT_B - 1));
        end
        1: begin
          rq  = REQ_FREE;
          ofs = OFS_W'($urandom_range(0, NUM_U - 1) * UNIT_B);
        end
        default: begin
        end
      endcase
    end else if (live_ofs.size() != 0 &&
                 ((live_ofs.size() >= fill_target) ? (roll < 70) : (roll < 35))) begin
      rq   = REQ_FREE;
      pick = $urandom_range(0, live_ofs.size() - 1);
      ofs  = OFS_W'(live_ofs[pick]);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        ord = $urandom_range(0, 3);
      end else if (roll < 95) begin
        ord = $urandom_range(4, 6);
      end else begin
        ord = $urandom_range(7, MAX_ORD);
      end
      if (ord == 0) begin
        sz = SIZE_W'($urandom_range(0, UNIT_B));
      end else begin
        sz = SIZE_W'($urandom_range((UNIT_B << (ord - 1)) + 1, UNIT_B << ord));
      end
    end
  endtask

  task automatic take_response();
    alloc_resp_t got;
    alloc_resp_t want_r;
    got.st  = status_o;
    got.ofs = result_offset_o;
    got.ord = result_order_o;
    if (resp_q.size() == 0) begin
      if (bad_beats < MAX_REPORTS) begin
        $display("Unexpected response beat: status %0d offset %0d order %0d",
                 got.st, got.ofs, got.ord);
      end
      bad_beats++;
    end else begin
      want_r = resp_q.pop_front();
      if (got.st !== want_r.st || got.ofs !== want_r.ofs || got.ord !== want_r.ord) begin
        if (bad_beats < MAX_REPORTS) begin
          $display("Mismatch: expected status %0d offset %0d order %0d, got %0d %0d %0d",
                   want_r.st, want_r.ofs, want_r.ord, got.st, got.ofs, got.ord);
        end
        bad_beats++;
      end
    end
  endtask

  initial begin : response_side
    int hold_left;
    int hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) take_response();
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d responses outstanding",
               quiet_cycles, resp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : request_side
    dir_row_t          rows [N_DIRECTED];
    logic              rq;
    logic [SIZE_W-1:0] sz;
    logic [OFS_W-1:0]  ofs;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_ALLOC;
    request_size_i = '0;
    block_offset_i = '0;
    pool_reset();
    send_idle_pct = 14;
    recv_idle_pct = 72;
    rows = '{
      '{REQ_ALLOC, 15'd0,     14'd0,     1'b1, '{ST_OK,      14'd0, 4'd0}},
      '{REQ_FREE,  15'd0,     14'd0,     1'b1, '{ST_OK,      14'd0, 4'd10}},
      '{REQ_ALLOC, 15'd16384, 14'd16383, 1'b1, '{ST_OK,      14'd0, 4'd10}},
      '{REQ_ALLOC, 15'd1,     14'd0,     1'b1, '{ST_NOMEM,   14'd0, 4'd0}},
      '{REQ_FREE,  15'd32767, 14'd16383, 1'b1, '{ST_BADFREE, 14'd0, 4'd0}},
      '{REQ_FREE,  15'd0,     14'd0,     1'b1, '{ST_OK,      14'd0, 4'd10}},
      '{REQ_FREE,  15'd0,     14'd0,     1'b1, '{ST_BADFREE, 14'd0, 4'd0}},
      '{REQ_FREE,  15'd0,     14'd8,     1'b1, '{ST_BADFREE, 14'd0, 4'd0}},
      '{REQ_ALLOC, 15'd16,    14'd0,     1'b1, '{ST_OK,      14'd0, 4'd0}},
      '{REQ_ALLOC, 15'd17,    14'd0,     1'b0, '0},
      '{REQ_ALLOC, 15'd8192,  14'd0,     1'b0, '0},
      '{REQ_ALLOC, 15'd4096,  14'd0,     1'b0, '0},
      '{REQ_FREE,  15'd0,     14'd16,    1'b1, '{ST_BADFREE, 14'd0, 4'd0}},
      '{REQ_FREE,  15'd0,     14'd16368, 1'b1, '{ST_BADFREE, 14'd0, 4'd0}},
      '{REQ_ALLOC, 15'd15,    14'd0,     1'b0, '0},
      '{REQ_FREE,  15'd0,     14'd32,    1'b0, '0},
      '{REQ_ALLOC, 15'd16383, 14'd0,     1'b1, '{ST_NOMEM,   14'd0, 4'd0}},
      '{REQ_FREE,  15'd0,     14'd0,     1'b0, '0},
      '{REQ_FREE,  15'd0,     14'd16,    1'b0, '0},
      '{REQ_ALLOC, 15'd32,    14'd0,     1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      issue_request(rows[i].rq, rows[i].size, rows[i].ofs, rows[i].fixed, rows[i].resp);
    end
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 14 : (p == 1) ? 72 : 0;
      recv_idle_pct = (p == 0) ? 72 : (p == 1) ? 14 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) begin
          fill_target = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(2, 60);
        end
        if (p == 2 && n == 200) hold_reqs <= hold_reqs + 1;
        draw_request(rq, sz, ofs);
        issue_request(rq, sz, ofs, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
      while (resp_q.size() != 0) @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    if (bad_beats == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
